/* src/sovn_pkg.sv */
package sovn_pkg;

  localparam int DIMENSIONS_DEF = 3;
  localparam int COORD_BITS_DEF = 32;

  localparam int MAX_DIM   = 3;
  localparam int MAX_NEIGH = 27;
  localparam int MAG_BITS  = 5;
  localparam int IDX_BITS  = 5;

  localparam logic [MAG_BITS-1:0] MAG_MIN = 5'd1;
  localparam logic [MAG_BITS-1:0] MAG_MAX = 5'd29;

  localparam int SIDE_BITS = 30;
  localparam int SQ_BITS   = 2 * SIDE_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;

  typedef logic [1:0] digit_t;
  localparam digit_t DIGIT_MINUS = 2'd0;
  localparam digit_t DIGIT_MID   = 2'd1;
  localparam digit_t DIGIT_PLUS  = 2'd2;

  typedef digit_t [MAX_DIM-1:0] digit_row_t;
  typedef digit_row_t [MAX_NEIGH-1:0] digit_tab_t;

  function automatic int ctr_bits(int cb);
    return ((cb > SIDE_BITS) ? cb : SIDE_BITS) + 2;
  endfunction

  function automatic digit_tab_t gen_digit_tab();
    digit_tab_t tab;
    digit_row_t row;
    logic       carry;
    row = '0;
    tab = '0;
    for (int k = 0; k < MAX_NEIGH; k++) begin
      tab[k] = row;
      carry  = 1'b1;
      for (int d = 0; d < MAX_DIM; d++) begin
        if (carry) begin
          if (row[d] == DIGIT_PLUS) begin
            row[d] = DIGIT_MINUS;
          end else begin
            row[d] = row[d] + 2'd1;
            carry  = 1'b0;
          end
        end
      end
    end
    return tab;
  endfunction

  localparam digit_tab_t DIGIT_TAB = gen_digit_tab();

endpackage

/* src/sovn_axis.sv */
module sovn_axis import sovn_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CTR_BITS = ctr_bits(COORD_BITS)
) (
  input  logic                  clk_i,
  input  logic                  en_b_i,
  input  logic                  en_c_i,
  input  logic [COORD_BITS-1:0] loc_i,
  input  logic [SIDE_BITS-1:0]  side_i,
  input  logic [SIDE_BITS-1:0]  half_i,
  output logic [CTR_BITS-1:0]   ctr_o,
  output logic [SQ_BITS-1:0]    dplus_o,
  output logic [SQ_BITS-1:0]    dminus_o
);

  logic [CTR_BITS-1:0]  loc_x, side_x, half_x, low_mask, low_x, base_x, ctr_d;
  logic                 neg, low_nz;
  logic [SIDE_BITS-1:0] u_d, v_d;

  logic [CTR_BITS-1:0]  ctr_b_q, ctr_c_q;
  logic [SIDE_BITS-1:0] u_b_q, v_b_q;
  logic [SQ_BITS-1:0]   dplus_q, dminus_q;

  assign loc_x    = {{(CTR_BITS-COORD_BITS){loc_i[COORD_BITS-1]}}, loc_i};
  assign side_x   = {{(CTR_BITS-SIDE_BITS){1'b0}}, side_i};
  assign half_x   = {{(CTR_BITS-SIDE_BITS){1'b0}}, half_i};
  assign low_mask = side_x - {{(CTR_BITS-1){1'b0}}, 1'b1};
  assign low_x    = loc_x & low_mask;
  assign neg      = loc_i[COORD_BITS-1];
  assign low_nz   = |low_x;
  assign base_x   = (loc_x & ~low_mask) + ((neg && low_nz) ? side_x : '0);
  assign ctr_d    = neg ? (base_x - half_x) : (base_x + half_x);
  assign u_d      = (neg && !low_nz) ? '0 : (side_i - low_x[SIDE_BITS-1:0]);
  assign v_d      = side_i - u_d;

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      ctr_b_q <= ctr_d;
      u_b_q   <= u_d;
      v_b_q   <= v_d;
    end
    if (en_c_i) begin
      ctr_c_q  <= ctr_b_q;
      dplus_q  <= u_b_q * u_b_q;
      dminus_q <= v_b_q * v_b_q;
    end
  end

  assign ctr_o    = ctr_c_q;
  assign dplus_o  = dplus_q;
  assign dminus_o = dminus_q;

endmodule

/* src/sovn_sel.sv */
module sovn_sel import sovn_pkg::*; #(
  parameter int DIMENSIONS = DIMENSIONS_DEF,
  localparam int NEIGH = 3 ** DIMENSIONS
) (
  input  logic [DIMENSIONS-1:0][SQ_BITS-1:0] dplus_i,
  input  logic [DIMENSIONS-1:0][SQ_BITS-1:0] dminus_i,
  input  logic [SUM_BITS-1:0]                rad_i,
  output logic [NEIGH-1:0]                   mask_o
);

  always_comb begin
    logic [SUM_BITS-1:0] sum;
    mask_o = '0;
    for (int k = 0; k < NEIGH; k++) begin
      sum = '0;
      for (int d = 0; d < DIMENSIONS; d++) begin
        case (DIGIT_TAB[k][d])
          DIGIT_MINUS: sum = sum + SUM_BITS'(dminus_i[d]);
          DIGIT_PLUS:  sum = sum + SUM_BITS'(dplus_i[d]);
          default:     sum = sum;
        endcase
      end
      mask_o[k] = (sum < rad_i);
    end
  end

endmodule

/* src/sovn_emit.sv */
module sovn_emit import sovn_pkg::*; #(
  parameter int DIMENSIONS = DIMENSIONS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int NEIGH = 3 ** DIMENSIONS,
  localparam int CTR_BITS = ctr_bits(COORD_BITS)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [NEIGH-1:0]                     mask_i,
  input  logic [DIMENSIONS-1:0][CTR_BITS-1:0]  ctr_i,
  input  logic [SIDE_BITS-1:0]                 side_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [MAX_DIM-1:0][COORD_BITS:0]     center_o,
  output logic [IDX_BITS-1:0]                  idx_o,
  output logic                                 last_o
);

  logic                                busy_q, ov_q;
  logic [NEIGH-1:0]                    mask_q, rest;
  logic [DIMENSIONS-1:0][CTR_BITS-1:0] ctr_q;
  logic [SIDE_BITS-1:0]                side_q;
  logic [MAX_DIM-1:0][COORD_BITS:0]    cen_d, cen_q;
  logic [IDX_BITS-1:0]                 sel, idx_q;
  logic                                last_q, fire;

  always_comb begin
    sel = '0;
    for (int k = NEIGH - 1; k >= 0; k--) begin
      if (mask_q[k]) sel = IDX_BITS'(k);
    end
  end

  assign rest    = mask_q & (mask_q - {{(NEIGH-1){1'b0}}, 1'b1});
  assign fire    = busy_q && (!ov_q || ready_i);
  assign ready_o = !busy_q || (fire && (rest == '0));

  for (genvar d = 0; d < MAX_DIM; d++) begin : g_cen
    if (d < DIMENSIONS) begin : g_on
      logic [CTR_BITS:0] ctr_x, side_x, nb;
      assign ctr_x  = {ctr_q[d][CTR_BITS-1], ctr_q[d]};
      assign side_x = {{(CTR_BITS+1-SIDE_BITS){1'b0}}, side_q};
      always_comb begin
        case (DIGIT_TAB[sel][d])
          DIGIT_MINUS: nb = ctr_x - side_x;
          DIGIT_PLUS:  nb = ctr_x + side_x;
          default:     nb = ctr_x;
        endcase
      end
      assign cen_d[d] = nb[COORD_BITS:0];
    end else begin : g_off
      assign cen_d[d] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (ready_o) busy_q <= valid_i;
      if (fire) begin
        ov_q <= 1'b1;
      end else if (ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      mask_q <= mask_i;
      ctr_q  <= ctr_i;
      side_q <= side_i;
    end else if (fire) begin
      mask_q <= rest;
    end
    if (fire) begin
      cen_q  <= cen_d;
      idx_q  <= sel;
      last_q <= (rest == '0);
    end
  end

  assign valid_o  = ov_q;
  assign center_o = cen_q;
  assign idx_o    = idx_q;
  assign last_o   = last_q;

endmodule

/* src/sphere_overlap_neighbor_cells_top.sv */
// Neighbor cells of a grid cell reached by a sphere around a point.
//
// Input channel s_axis: one word per point, carrying three signed coordinates
// and a cell level m (side 2^m; levels below 1 act as 1, above 29 as 29).
// Output channel m_axis: one word per selected neighbor cell, carrying its
// center (one bit wider than a coordinate) and its base-three cell index, in
// increasing index order; tlast marks the final cell of a point.
//
// A point passes the input, cell-center and square registers; the emit stage
// then registers each cell it sends, one per cycle while tready is high, and
// holds the point until all its selected cells (1 to 3^DIMENSIONS, 27 in 3D)
// are out. Single-cell points stream at one per cycle while tready is high.
// The front pipeline (cell center, squares, distance compare) takes a point
// every cycle unless the emit stage is busy.
// Reset clears all valid bits; nothing else needs clearing. When the receiver
// holds tready low, the output word holds, the emit stage and pipeline fill,
// and s_axis_tready drops; no word is lost or repeated.
module sphere_overlap_neighbor_cells_top import sovn_pkg::*; #(
  parameter int DIMENSIONS = DIMENSIONS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W  = ((3 * COORD_BITS + MAG_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * (COORD_BITS + 1) + IDX_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // coord_0, coord_1, coord_2, magnitude
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // center_0, center_1, center_2, cell_index
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int NEIGH    = 3 ** DIMENSIONS;
  localparam int CTR_BITS = ctr_bits(COORD_BITS);

  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c, en_d;

  logic [MAG_BITS-1:0] mag_raw, mag_d, mag_a_q;
  logic [DIMENSIONS-1:0][COORD_BITS-1:0] loc_a_q;
  logic [SIDE_BITS-1:0] side_a, half_a, side_b_q, side_c_q;
  logic [SUM_BITS-1:0]  rad_b_q, rad_c_q;

  logic [DIMENSIONS-1:0][CTR_BITS-1:0] ctr_c;
  logic [DIMENSIONS-1:0][SQ_BITS-1:0]  dplus_c, dminus_c;
  logic [NEIGH-1:0]                    mask_c;

  logic [MAX_DIM-1:0][COORD_BITS:0] center;
  logic [IDX_BITS-1:0]              cell_idx;

  assign en_c = !vc_q || en_d;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign s_axis_tready = en_a;

  assign mag_raw = s_axis_tdata[3*COORD_BITS +: MAG_BITS];
  assign mag_d   = (mag_raw < MAG_MIN) ? MAG_MIN :
                   (mag_raw > MAG_MAX) ? MAG_MAX : mag_raw;

  assign side_a = {{(SIDE_BITS-1){1'b0}}, 1'b1} << mag_a_q;
  assign half_a = side_a >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= s_axis_tvalid;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      mag_a_q <= mag_d;
      for (int d = 0; d < DIMENSIONS; d++) begin
        loc_a_q[d] <= s_axis_tdata[d*COORD_BITS +: COORD_BITS];
      end
    end
    if (en_b) begin
      side_b_q <= side_a;
      rad_b_q  <= SUM_BITS'(DIMENSIONS) << ({1'b0, mag_a_q, 1'b0} - 7'd2);
    end
    if (en_c) begin
      side_c_q <= side_b_q;
      rad_c_q  <= rad_b_q;
    end
  end

  for (genvar d = 0; d < DIMENSIONS; d++) begin : g_axis
    sovn_axis #(
      .COORD_BITS (COORD_BITS)
    ) u_axis (
      .clk_i    (clk_i),
      .en_b_i   (en_b),
      .en_c_i   (en_c),
      .loc_i    (loc_a_q[d]),
      .side_i   (side_a),
      .half_i   (half_a),
      .ctr_o    (ctr_c[d]),
      .dplus_o  (dplus_c[d]),
      .dminus_o (dminus_c[d])
    );
  end

  sovn_sel #(
    .DIMENSIONS (DIMENSIONS)
  ) u_sel (
    .dplus_i  (dplus_c),
    .dminus_i (dminus_c),
    .rad_i    (rad_c_q),
    .mask_o   (mask_c)
  );

  sovn_emit #(
    .DIMENSIONS (DIMENSIONS),
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vc_q),
    .ready_o  (en_d),
    .mask_i   (mask_c),
    .ctr_i    (ctr_c),
    .side_i   (side_c_q),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .center_o (center),
    .idx_o    (cell_idx),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({cell_idx, center[2], center[1], center[0]});

endmodule
